### sv/snmph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNMP header parser package
// Shared types, phase codes, tag constants and result status codes.
// ----------------------------------------------------------------------------
package snmph_pkg;

  localparam logic [7:0] TAG_SEQ      = 8'h30;
  localparam logic [7:0] TAG_INT      = 8'h02;
  localparam logic [7:0] TAG_OCTETS   = 8'h04;
  localparam logic [7:0] TAG_OID      = 8'h06;
  localparam logic [7:0] TAG_IPADDR   = 8'h40;
  localparam logic [7:0] TAG_TICKS    = 8'h43;
  localparam logic [7:0] TAG_TRAP_V1  = 8'hA4;
  localparam logic [7:0] TAG_GET_REQ  = 8'hA0;
  localparam logic [7:0] LEN_LONG_BIT = 8'h80;

  localparam int unsigned TRAP_FIELDS = 5;
  localparam int unsigned TRAP_IDX_W  = 3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SEQ      = 4'd1;
  localparam logic [3:0] ST_VER      = 4'd2;
  localparam logic [3:0] ST_COMM     = 4'd3;
  localparam logic [3:0] ST_REQID    = 4'd4;
  localparam logic [3:0] ST_ERRST    = 4'd5;
  localparam logic [3:0] ST_ERRIDX   = 4'd6;
  localparam logic [3:0] ST_TRAPFLD  = 4'd7;
  localparam logic [3:0] ST_VARBIND  = 4'd8;
  localparam logic [3:0] ST_TRUNC    = 4'd9;

  localparam logic [1:0] VER_V1  = 2'd0;
  localparam logic [1:0] VER_V2C = 2'd1;
  localparam logic [1:0] VER_V3  = 2'd2;

  localparam logic [7:0] VER_BYTE_V1 = 8'd0;
  localparam logic [7:0] VER_BYTE_V3 = 8'd3;

  typedef enum logic [25:0] {
    PH_SEQ_TAG   = 26'd1 << 0,
    PH_SEQ_LEN   = 26'd1 << 1,
    PH_SEQ_SKIP  = 26'd1 << 2,
    PH_VER_TAG   = 26'd1 << 3,
    PH_VER_LEN   = 26'd1 << 4,
    PH_VER_BODY  = 26'd1 << 5,
    PH_COMM_TAG  = 26'd1 << 6,
    PH_COMM_LEN  = 26'd1 << 7,
    PH_COMM_BODY = 26'd1 << 8,
    PH_PDU_TAG   = 26'd1 << 9,
    PH_PDU_LEN   = 26'd1 << 10,
    PH_PDU_SKIP  = 26'd1 << 11,
    PH_REQ_TAG   = 26'd1 << 12,
    PH_REQ_LEN   = 26'd1 << 13,
    PH_REQ_BODY  = 26'd1 << 14,
    PH_ERR_TAG   = 26'd1 << 15,
    PH_ERR_LEN   = 26'd1 << 16,
    PH_ERR_BODY  = 26'd1 << 17,
    PH_IDX_TAG   = 26'd1 << 18,
    PH_IDX_LEN   = 26'd1 << 19,
    PH_IDX_BODY  = 26'd1 << 20,
    PH_TRP_TAG   = 26'd1 << 21,
    PH_TRP_LEN   = 26'd1 << 22,
    PH_TRP_BODY  = 26'd1 << 23,
    PH_VB_TAG    = 26'd1 << 24,
    PH_DONE      = 26'd1 << 25
  } phase_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  snmp_version;
    logic [7:0]  community_length;
    logic [7:0]  pdu_tag;
    logic        is_trap;
    logic [31:0] request_id;
    logic [7:0]  error_status;
  } res_t;

  function automatic logic [7:0] trap_tag(input logic [TRAP_IDX_W-1:0] idx);
    logic [7:0] t;
    case (idx)
      3'd0:    t = TAG_OID;
      3'd1:    t = TAG_IPADDR;
      3'd2:    t = TAG_INT;
      3'd3:    t = TAG_INT;
      3'd4:    t = TAG_TICKS;
      default: t = TAG_INT;
    endcase
    return t;
  endfunction

endpackage

### sv/snmph_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNMP header parser channels
// Valid/ready channels for message bytes and for summary results.
// ----------------------------------------------------------------------------
interface snmph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface snmph_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [1:0]  snmp_version;
  logic [7:0]  community_length;
  logic [7:0]  pdu_tag;
  logic        is_trap;
  logic [31:0] request_id;
  logic [7:0]  error_status;

  modport source (output valid, output status, output snmp_version,
                  output community_length, output pdu_tag, output is_trap,
                  output request_id, output error_status, input ready);
  modport sink   (input valid, input status, input snmp_version,
                  input community_length, input pdu_tag, input is_trap,
                  input request_id, input error_status, output ready);
endinterface

### sv/snmph_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNMP header parser state machine
// Walks the BER header one byte per cycle while bytes are accepted and raises at most one result per message.
// ----------------------------------------------------------------------------
module snmph_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  output logic               res_valid,
  output snmph_pkg::res_t    res
);

  snmph_pkg::phase_t                phase_r, phase_nxt;
  logic [7:0]                       skip_r, skip_nxt;
  logic                             first_r, first_nxt;
  logic [1:0]                       ver_r, ver_nxt;
  logic [7:0]                       comm_len_r, comm_len_nxt;
  logic [7:0]                       pdu_r, pdu_nxt;
  logic [31:0]                      reqid_r, reqid_nxt;
  logic [7:0]                       errst_r, errst_nxt;
  logic [snmph_pkg::TRAP_IDX_W-1:0] trap_idx_r, trap_idx_nxt;

  logic [7:0]  cnt_dec;
  logic        body_done;
  logic [7:0]  outer_n;
  logic        hit;
  logic [3:0]  hit_status;
  logic        pdu_is_trap;
  snmph_pkg::phase_t after_pdu;
  snmph_pkg::phase_t after_trap;

  assign cnt_dec     = (skip_r != 8'd0) ? skip_r - 8'd1 : 8'd0;
  assign body_done   = (cnt_dec == 8'd0);
  assign outer_n     = data_byte[7] ? {1'b0, data_byte[6:0]} : 8'd0;
  assign pdu_is_trap = (pdu_r == snmph_pkg::TAG_TRAP_V1);
  assign after_pdu   = pdu_is_trap ? snmph_pkg::PH_TRP_TAG : snmph_pkg::PH_REQ_TAG;
  assign after_trap  = (trap_idx_r >= 3'(snmph_pkg::TRAP_FIELDS)) ?
                       snmph_pkg::PH_VB_TAG : snmph_pkg::PH_TRP_TAG;

  always_comb begin
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    first_nxt    = first_r;
    ver_nxt      = ver_r;
    comm_len_nxt = comm_len_r;
    pdu_nxt      = pdu_r;
    reqid_nxt    = reqid_r;
    errst_nxt    = errst_r;
    trap_idx_nxt = trap_idx_r;
    hit          = 1'b0;
    hit_status   = snmph_pkg::ST_OK;
    res_valid    = 1'b0;
    res          = '0;

    if (acc && phase_r != snmph_pkg::PH_DONE) begin
      case (phase_r)
        snmph_pkg::PH_SEQ_TAG: begin
          if (data_byte != snmph_pkg::TAG_SEQ) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_SEQ;
          end else begin
            phase_nxt = snmph_pkg::PH_SEQ_LEN;
          end
        end
        snmph_pkg::PH_SEQ_LEN: begin
          skip_nxt  = outer_n;
          phase_nxt = (outer_n != 8'd0) ? snmph_pkg::PH_SEQ_SKIP : snmph_pkg::PH_VER_TAG;
        end
        snmph_pkg::PH_SEQ_SKIP: begin
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = snmph_pkg::PH_VER_TAG;
        end
        snmph_pkg::PH_VER_TAG: begin
          if (data_byte != snmph_pkg::TAG_INT) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_VER;
          end else begin
            phase_nxt = snmph_pkg::PH_VER_LEN;
          end
        end
        snmph_pkg::PH_VER_LEN: begin
          if (data_byte == 8'd0) ver_nxt = snmph_pkg::VER_V2C;
          skip_nxt  = data_byte;
          first_nxt = (data_byte != 8'd0);
          phase_nxt = (data_byte != 8'd0) ? snmph_pkg::PH_VER_BODY : snmph_pkg::PH_COMM_TAG;
        end
        snmph_pkg::PH_VER_BODY: begin
          if (first_r) begin
            if (data_byte == snmph_pkg::VER_BYTE_V1)      ver_nxt = snmph_pkg::VER_V1;
            else if (data_byte == snmph_pkg::VER_BYTE_V3) ver_nxt = snmph_pkg::VER_V3;
            else                                          ver_nxt = snmph_pkg::VER_V2C;
          end
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = snmph_pkg::PH_COMM_TAG;
        end
        snmph_pkg::PH_COMM_TAG: begin
          if (data_byte != snmph_pkg::TAG_OCTETS) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_COMM;
          end else begin
            phase_nxt = snmph_pkg::PH_COMM_LEN;
          end
        end
        snmph_pkg::PH_COMM_LEN: begin
          comm_len_nxt = data_byte;
          skip_nxt     = data_byte;
          first_nxt    = (data_byte != 8'd0);
          phase_nxt    = (data_byte != 8'd0) ? snmph_pkg::PH_COMM_BODY : snmph_pkg::PH_PDU_TAG;
        end
        snmph_pkg::PH_COMM_BODY: begin
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = snmph_pkg::PH_PDU_TAG;
        end
        snmph_pkg::PH_PDU_TAG: begin
          pdu_nxt   = data_byte;
          phase_nxt = snmph_pkg::PH_PDU_LEN;
        end
        snmph_pkg::PH_PDU_LEN: begin
          trap_idx_nxt = '0;
          skip_nxt     = outer_n;
          phase_nxt    = (outer_n != 8'd0) ? snmph_pkg::PH_PDU_SKIP : after_pdu;
        end
        snmph_pkg::PH_PDU_SKIP: begin
          trap_idx_nxt = '0;
          first_nxt    = 1'b0;
          skip_nxt     = cnt_dec;
          if (body_done) phase_nxt = after_pdu;
        end
        snmph_pkg::PH_REQ_TAG: begin
          if (data_byte != snmph_pkg::TAG_INT) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_REQID;
          end else begin
            phase_nxt = snmph_pkg::PH_REQ_LEN;
          end
        end
        snmph_pkg::PH_REQ_LEN: begin
          reqid_nxt = '0;
          skip_nxt  = data_byte;
          first_nxt = (data_byte != 8'd0);
          phase_nxt = (data_byte != 8'd0) ? snmph_pkg::PH_REQ_BODY : snmph_pkg::PH_ERR_TAG;
        end
        snmph_pkg::PH_REQ_BODY: begin
          reqid_nxt = {reqid_r[23:0], data_byte};
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = snmph_pkg::PH_ERR_TAG;
        end
        snmph_pkg::PH_ERR_TAG: begin
          if (data_byte != snmph_pkg::TAG_INT) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_ERRST;
          end else begin
            phase_nxt = snmph_pkg::PH_ERR_LEN;
          end
        end
        snmph_pkg::PH_ERR_LEN: begin
          errst_nxt = '0;
          skip_nxt  = data_byte;
          first_nxt = (data_byte != 8'd0);
          phase_nxt = (data_byte != 8'd0) ? snmph_pkg::PH_ERR_BODY : snmph_pkg::PH_IDX_TAG;
        end
        snmph_pkg::PH_ERR_BODY: begin
          if (first_r) errst_nxt = data_byte;
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = snmph_pkg::PH_IDX_TAG;
        end
        snmph_pkg::PH_IDX_TAG: begin
          if (data_byte != snmph_pkg::TAG_INT) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_ERRIDX;
          end else begin
            phase_nxt = snmph_pkg::PH_IDX_LEN;
          end
        end
        snmph_pkg::PH_IDX_LEN: begin
          skip_nxt  = data_byte;
          first_nxt = (data_byte != 8'd0);
          phase_nxt = (data_byte != 8'd0) ? snmph_pkg::PH_IDX_BODY : snmph_pkg::PH_VB_TAG;
        end
        snmph_pkg::PH_IDX_BODY: begin
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = snmph_pkg::PH_VB_TAG;
        end
        snmph_pkg::PH_TRP_TAG: begin
          if (trap_idx_r >= 3'(snmph_pkg::TRAP_FIELDS) ||
              data_byte != snmph_pkg::trap_tag(trap_idx_r)) begin
            hit = 1'b1;
            hit_status = snmph_pkg::ST_TRAPFLD;
          end else begin
            trap_idx_nxt = trap_idx_r + 3'd1;
            phase_nxt    = snmph_pkg::PH_TRP_LEN;
          end
        end
        snmph_pkg::PH_TRP_LEN: begin
          skip_nxt  = data_byte;
          first_nxt = (data_byte != 8'd0);
          phase_nxt = (data_byte != 8'd0) ? snmph_pkg::PH_TRP_BODY : after_trap;
        end
        snmph_pkg::PH_TRP_BODY: begin
          first_nxt = 1'b0;
          skip_nxt  = cnt_dec;
          if (body_done) phase_nxt = after_trap;
        end
        snmph_pkg::PH_VB_TAG: begin
          hit = 1'b1;
          hit_status = (data_byte != snmph_pkg::TAG_SEQ) ? snmph_pkg::ST_VARBIND
                                                         : snmph_pkg::ST_OK;
        end
        default: begin
        end
      endcase

      if (hit) begin
        phase_nxt  = snmph_pkg::PH_DONE;
        res_valid  = 1'b1;
        res.status = hit_status;
        if (hit_status == snmph_pkg::ST_OK) begin
          res.snmp_version     = ver_r;
          res.community_length = comm_len_r;
          res.pdu_tag          = pdu_r;
          res.is_trap          = pdu_is_trap;
          res.request_id       = pdu_is_trap ? 32'd0 : reqid_r;
          res.error_status     = pdu_is_trap ? 8'd0 : errst_r;
        end
      end else if (end_of_message) begin
        res_valid  = 1'b1;
        res.status = snmph_pkg::ST_TRUNC;
      end
    end

    if (acc && end_of_message) begin
      phase_nxt    = snmph_pkg::PH_SEQ_TAG;
      skip_nxt     = '0;
      first_nxt    = 1'b0;
      ver_nxt      = snmph_pkg::VER_V2C;
      comm_len_nxt = '0;
      pdu_nxt      = snmph_pkg::TAG_GET_REQ;
      reqid_nxt    = '0;
      errst_nxt    = '0;
      trap_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= snmph_pkg::PH_SEQ_TAG;
      skip_r     <= '0;
      first_r    <= 1'b0;
      ver_r      <= snmph_pkg::VER_V2C;
      comm_len_r <= '0;
      pdu_r      <= snmph_pkg::TAG_GET_REQ;
      reqid_r    <= '0;
      errst_r    <= '0;
      trap_idx_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      first_r    <= first_nxt;
      ver_r      <= ver_nxt;
      comm_len_r <= comm_len_nxt;
      pdu_r      <= pdu_nxt;
      reqid_r    <= reqid_nxt;
      errst_r    <= errst_nxt;
      trap_idx_r <= trap_idx_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && end_of_message |=> phase_r == snmph_pkg::PH_SEQ_TAG)
    else $error("parser did not restart after end of message");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == snmph_pkg::PH_DONE |-> !res_valid)
    else $error("result raised after message was already resolved");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != snmph_pkg::ST_OK |->
      res.request_id == 32'd0 && res.pdu_tag == 8'd0 && res.error_status == 8'd0)
    else $error("error result carries nonzero fields");

  a_trap_idx: assert property (@(posedge clk) disable iff (!rst_n)
    trap_idx_r <= 3'(snmph_pkg::TRAP_FIELDS))
    else $error("trap field index out of range");
`endif

endmodule

### sv/snmph_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNMP header parser result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module snmph_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ld,
  input  snmph_pkg::res_t ld_res,
  output logic            space,
  snmph_out_if.source     out_ch
);

  logic            valid_r, valid_nxt;
  snmph_pkg::res_t res_r;

  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) valid_nxt = 1'b0;
    if (ld)           valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= ld_res;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.status           = res_r.status;
  assign out_ch.snmp_version     = res_r.snmp_version;
  assign out_ch.community_length = res_r.community_length;
  assign out_ch.pdu_tag          = res_r.pdu_tag;
  assign out_ch.is_trap          = res_r.is_trap;
  assign out_ch.request_id       = res_r.request_id;
  assign out_ch.error_status     = res_r.error_status;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> space)
    else $error("result loaded while a stalled word is pending");
`endif

endmodule

### sv/snmp_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNMP header parser
// Checks the BER header of an SNMP message and reports one summary per message.
//
// Usage:
//   in_ch carries one message byte per word with an end-of-message mark on
//   the final byte. out_ch carries at most one result word per message: a
//   summary when the varbind sequence tag is reached, an error code at the
//   first bad tag, or a truncation code when the message ends early.
//   Throughput is one byte per cycle. A result appears on out_ch in the cycle
//   after the byte that causes it is accepted; the parser state and the
//   result register are the only stages.
//   When out_ch stalls with a word pending, in_ch.ready drops until the
//   word is taken; with no word pending bytes keep flowing.
//   Reset (rst_n low, synchronous) clears the result valid flag and returns
//   the parser to expect a message sequence tag. Every end-of-message byte
//   returns the parser to the same state.
// ----------------------------------------------------------------------------
module snmp_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  snmph_in_if.sink     in_ch,
  snmph_out_if.source  out_ch
);

  logic            acc;
  logic            space;
  logic            res_valid;
  snmph_pkg::res_t res;

  assign in_ch.ready = space;
  assign acc         = in_ch.valid && space;

  snmph_fsm u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .data_byte      (in_ch.data_byte),
    .end_of_message (in_ch.end_of_message),
    .res_valid      (res_valid),
    .res            (res)
  );

  snmph_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (res_valid),
    .ld_res (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

### sim/tb_snmp_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNMP header parser testbench
// Streams SNMP messages into the parser byte by byte. Most messages are
// well formed with random content, and the rest have a bad tag, are cut
// short or are pure noise. A byte-level model of the header walk predicts
// the summary or error word for each message. Every word taken from the
// parser is compared field by field with the oldest prediction. The run
// passes through phases of sender gaps and receiver stalls, and it holds the
// result channel off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_snmp_header_parser;

  localparam int unsigned PHASE_BYTES  = 400;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 20;

  class summary_scoreboard;
    snmph_pkg::phase_t stage;
    logic [7:0]        skip_left;
    bit                first_body;
    logic [1:0]        version;
    logic [7:0]        comm_len;
    logic [7:0]        pdu;
    logic [31:0]       req_id;
    logic [7:0]        err_status;
    int unsigned       trap_pos;
    int unsigned       sent_bytes;
    int unsigned       fail_count;
    snmph_pkg::res_t   due_summaries[$];
    logic [7:0]        trap_seq[snmph_pkg::TRAP_FIELDS];

    function new();
      trap_seq = '{snmph_pkg::TAG_OID, snmph_pkg::TAG_IPADDR, snmph_pkg::TAG_INT,
                   snmph_pkg::TAG_INT, snmph_pkg::TAG_TICKS};
      sent_bytes = 0;
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      stage = snmph_pkg::PH_SEQ_TAG;
      skip_left = '0;
      first_body = 1'b0;
      version = snmph_pkg::VER_V2C;
      comm_len = '0;
      pdu = snmph_pkg::TAG_GET_REQ;
      req_id = '0;
      err_status = '0;
      trap_pos = 0;
    endfunction

    function void outer_len(logic [7:0] b, snmph_pkg::phase_t skip_ph,
                            snmph_pkg::phase_t next_ph);
      skip_left = ((b & snmph_pkg::LEN_LONG_BIT) != 0) ? (b & ~snmph_pkg::LEN_LONG_BIT)
                                                       : 8'd0;
      stage = (skip_left != 0) ? skip_ph : next_ph;
    endfunction

    function void inner_len(logic [7:0] b, snmph_pkg::phase_t body_ph,
                            snmph_pkg::phase_t next_ph);
      skip_left = b;
      first_body = (b != 0);
      stage = (b != 0) ? body_ph : next_ph;
    endfunction

    function void take_body(snmph_pkg::phase_t next_ph);
      first_body = 1'b0;
      if (skip_left != 0) skip_left--;
      if (skip_left == 0) stage = next_ph;
    endfunction

    function snmph_pkg::phase_t pdu_next();
      trap_pos = 0;
      return (pdu == snmph_pkg::TAG_TRAP_V1) ? snmph_pkg::PH_TRP_TAG : snmph_pkg::PH_REQ_TAG;
    endfunction

    function snmph_pkg::phase_t trap_next();
      return (trap_pos >= snmph_pkg::TRAP_FIELDS) ? snmph_pkg::PH_VB_TAG
                                                  : snmph_pkg::PH_TRP_TAG;
    endfunction

    // Walks one byte through the header. Returns 1 when the byte decides the
    // word for this message, with its status in st.
    function bit parse_byte(logic [7:0] b, output logic [3:0] st);
      st = snmph_pkg::ST_OK;
      case (stage)
        snmph_pkg::PH_SEQ_TAG: begin
          if (b != snmph_pkg::TAG_SEQ) begin
            st = snmph_pkg::ST_SEQ;
            return 1'b1;
          end
          stage = snmph_pkg::PH_SEQ_LEN;
        end
        snmph_pkg::PH_SEQ_LEN:  outer_len(b, snmph_pkg::PH_SEQ_SKIP, snmph_pkg::PH_VER_TAG);
        snmph_pkg::PH_SEQ_SKIP: take_body(snmph_pkg::PH_VER_TAG);
        snmph_pkg::PH_VER_TAG: begin
          if (b != snmph_pkg::TAG_INT) begin
            st = snmph_pkg::ST_VER;
            return 1'b1;
          end
          stage = snmph_pkg::PH_VER_LEN;
        end
        snmph_pkg::PH_VER_LEN: begin
          if (b == 0) version = snmph_pkg::VER_V2C;
          inner_len(b, snmph_pkg::PH_VER_BODY, snmph_pkg::PH_COMM_TAG);
        end
        snmph_pkg::PH_VER_BODY: begin
          if (first_body) begin
            if (b == snmph_pkg::VER_BYTE_V1)      version = snmph_pkg::VER_V1;
            else if (b == snmph_pkg::VER_BYTE_V3) version = snmph_pkg::VER_V3;
            else                                  version = snmph_pkg::VER_V2C;
          end
          take_body(snmph_pkg::PH_COMM_TAG);
        end
        snmph_pkg::PH_COMM_TAG: begin
          if (b != snmph_pkg::TAG_OCTETS) begin
            st = snmph_pkg::ST_COMM;
            return 1'b1;
          end
          stage = snmph_pkg::PH_COMM_LEN;
        end
        snmph_pkg::PH_COMM_LEN: begin
          comm_len = b;
          inner_len(b, snmph_pkg::PH_COMM_BODY, snmph_pkg::PH_PDU_TAG);
        end
        snmph_pkg::PH_COMM_BODY: take_body(snmph_pkg::PH_PDU_TAG);
        snmph_pkg::PH_PDU_TAG: begin
          pdu = b;
          stage = snmph_pkg::PH_PDU_LEN;
        end
        snmph_pkg::PH_PDU_LEN:  outer_len(b, snmph_pkg::PH_PDU_SKIP, pdu_next());
        snmph_pkg::PH_PDU_SKIP: take_body(pdu_next());
        snmph_pkg::PH_REQ_TAG: begin
          if (b != snmph_pkg::TAG_INT) begin
            st = snmph_pkg::ST_REQID;
            return 1'b1;
          end
          stage = snmph_pkg::PH_REQ_LEN;
        end
        snmph_pkg::PH_REQ_LEN: begin
          req_id = '0;
          inner_len(b, snmph_pkg::PH_REQ_BODY, snmph_pkg::PH_ERR_TAG);
        end
        snmph_pkg::PH_REQ_BODY: begin
          req_id = {req_id[23:0], b};
          take_body(snmph_pkg::PH_ERR_TAG);
        end
        snmph_pkg::PH_ERR_TAG: begin
          if (b != snmph_pkg::TAG_INT) begin
            st = snmph_pkg::ST_ERRST;
            return 1'b1;
          end
          stage = snmph_pkg::PH_ERR_LEN;
        end
        snmph_pkg::PH_ERR_LEN: begin
          err_status = '0;
          inner_len(b, snmph_pkg::PH_ERR_BODY, snmph_pkg::PH_IDX_TAG);
        end
        snmph_pkg::PH_ERR_BODY: begin
          if (first_body) err_status = b;
          take_body(snmph_pkg::PH_IDX_TAG);
        end
        snmph_pkg::PH_IDX_TAG: begin
          if (b != snmph_pkg::TAG_INT) begin
            st = snmph_pkg::ST_ERRIDX;
            return 1'b1;
          end
          stage = snmph_pkg::PH_IDX_LEN;
        end
        snmph_pkg::PH_IDX_LEN:  inner_len(b, snmph_pkg::PH_IDX_BODY, snmph_pkg::PH_VB_TAG);
        snmph_pkg::PH_IDX_BODY: take_body(snmph_pkg::PH_VB_TAG);
        snmph_pkg::PH_TRP_TAG: begin
          if (trap_pos >= snmph_pkg::TRAP_FIELDS || b != trap_seq[trap_pos]) begin
            st = snmph_pkg::ST_TRAPFLD;
            return 1'b1;
          end
          trap_pos++;
          stage = snmph_pkg::PH_TRP_LEN;
        end
        snmph_pkg::PH_TRP_LEN:  inner_len(b, snmph_pkg::PH_TRP_BODY, trap_next());
        snmph_pkg::PH_TRP_BODY: take_body(trap_next());
        snmph_pkg::PH_VB_TAG: begin
          if (b != snmph_pkg::TAG_SEQ) st = snmph_pkg::ST_VARBIND;
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function snmph_pkg::res_t summarize(logic [3:0] st);
      snmph_pkg::res_t r;
      r = '0;
      r.status = st;
      if (st == snmph_pkg::ST_OK) begin
        r.snmp_version = version;
        r.community_length = comm_len;
        r.pdu_tag = pdu;
        r.is_trap = (pdu == snmph_pkg::TAG_TRAP_V1);
        r.request_id = r.is_trap ? 32'd0 : req_id;
        r.error_status = r.is_trap ? 8'd0 : err_status;
      end
      return r;
    endfunction

    function void queue_summary(snmph_pkg::res_t r);
      due_summaries.insert(due_summaries.size(), r);
    endfunction

    function void note_byte(logic [7:0] b, logic eom);
      logic [3:0] st;
      sent_bytes++;
      if (stage != snmph_pkg::PH_DONE) begin
        if (parse_byte(b, st)) begin
          queue_summary(summarize(st));
          stage = snmph_pkg::PH_DONE;
        end else if (eom) begin
          queue_summary(summarize(snmph_pkg::ST_TRUNC));
        end
      end
      if (eom) restart();
    endfunction

    function string show(snmph_pkg::res_t r);
      return $sformatf("st=%0d ver=%0d comm=%0d pdu=%02h trap=%0b id=%08h err=%02h",
                       r.status, r.snmp_version, r.community_length, r.pdu_tag,
                       r.is_trap, r.request_id, r.error_status);
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_summary(snmph_pkg::res_t got);
      snmph_pkg::res_t want;
      if (due_summaries.size() == 0) begin
        report({"unexpected word ", show(got)});
        return;
      end
      want = due_summaries.pop_front();
      if (got.status !== want.status || got.snmp_version !== want.snmp_version ||
          got.community_length !== want.community_length ||
          got.pdu_tag !== want.pdu_tag || got.is_trap !== want.is_trap ||
          got.request_id !== want.request_id || got.error_status !== want.error_status) begin
        report({"expected ", show(want), " got ", show(got)});
      end
    endfunction

    function int unsigned pending();
      return due_summaries.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  snmph_in_if  in_ch();
  snmph_out_if out_ch();

  snmp_header_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  summary_scoreboard summaries = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;

  logic [7:0]  msg_q[$];
  int unsigned tag_at[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void put_byte(logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic void mark_tag();
    tag_at.insert(tag_at.size(), msg_q.size());
  endfunction

  function automatic int unsigned pick_len(int unsigned hi);
    if ($urandom_range(199) == 0) return $urandom_range(255);
    return $urandom_range(hi);
  endfunction

  function automatic void add_field(logic [7:0] tag, int unsigned len);
    mark_tag();
    put_byte(tag);
    put_byte(len[7:0]);
    repeat (len) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void add_outer_len();
    int unsigned n;
    if ($urandom_range(9) < 6) begin
      put_byte(8'($urandom_range(127)));
    end else begin
      n = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(4);
      put_byte(snmph_pkg::LEN_LONG_BIT | n[7:0]);
      repeat (n) put_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_message();
    int unsigned len;
    int unsigned r;
    int unsigned pos;
    logic [7:0]  pdu_tag;
    logic [7:0]  flip;
    msg_q.delete();
    tag_at.delete();
    mark_tag();
    put_byte(snmph_pkg::TAG_SEQ);
    add_outer_len();
    len = pick_len(3);
    add_field(snmph_pkg::TAG_INT, len);
    if (len != 0) begin
      case ($urandom_range(3))
        0:       msg_q[msg_q.size() - len] = snmph_pkg::VER_BYTE_V1;
        1:       msg_q[msg_q.size() - len] = 8'd1;
        2:       msg_q[msg_q.size() - len] = snmph_pkg::VER_BYTE_V3;
        default: ;
      endcase
    end
    add_field(snmph_pkg::TAG_OCTETS, pick_len(10));
    r = $urandom_range(9);
    if (r < 4) pdu_tag = snmph_pkg::TAG_TRAP_V1;
    else if (r < 9) pdu_tag = snmph_pkg::TAG_GET_REQ | 8'($urandom_range(7));
    else pdu_tag = 8'($urandom_range(255));
    mark_tag();
    put_byte(pdu_tag);
    add_outer_len();
    if (pdu_tag == snmph_pkg::TAG_TRAP_V1) begin
      add_field(snmph_pkg::TAG_OID, pick_len(8));
      add_field(snmph_pkg::TAG_IPADDR, pick_len(4));
      add_field(snmph_pkg::TAG_INT, pick_len(2));
      add_field(snmph_pkg::TAG_INT, pick_len(2));
      add_field(snmph_pkg::TAG_TICKS, pick_len(4));
    end else begin
      add_field(snmph_pkg::TAG_INT, pick_len(8));
      add_field(snmph_pkg::TAG_INT, pick_len(2));
      add_field(snmph_pkg::TAG_INT, pick_len(2));
    end
    mark_tag();
    put_byte(snmph_pkg::TAG_SEQ);
    repeat ($urandom_range(6)) put_byte(8'($urandom_range(255)));

    r = $urandom_range(99);
    if (r < 30) begin
      pos = tag_at[$urandom_range(tag_at.size() - 1)];
      flip = 8'($urandom_range(255, 1));
      msg_q[pos] = msg_q[pos] ^ flip;
    end else if (r < 40) begin
      msg_q = msg_q[0:$urandom_range(msg_q.size() - 2)];
    end else if (r < 45) begin
      msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
    end else if (r < 49) begin
      msg_q.delete();
      repeat ($urandom_range(12, 1)) put_byte(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_byte(logic [7:0] d, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    summaries.note_byte(d, eom);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  initial begin
    snmph_pkg::res_t got;
    int unsigned     hold_left;
    bit              hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.snmp_version = out_ch.snmp_version;
        got.community_length = out_ch.community_length;
        got.pdu_tag = out_ch.pdu_tag;
        got.is_trap = out_ch.is_trap;
        got.request_id = out_ch.request_id;
        got.error_status = out_ch.error_status;
        summaries.check_summary(got);
      end
      if (hold_request && !hold_taken) begin
        hold_left = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned target;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_message <= 1'b0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two lone bad tags, a minimal request with every length zero and the
    // end mark on the varbind tag, then a message cut inside the version.
    msg_q = '{8'h00};
    send_message();
    msg_q = '{8'hFF};
    send_message();
    msg_q = '{snmph_pkg::TAG_SEQ, 8'h00, snmph_pkg::TAG_INT, 8'h00,
              snmph_pkg::TAG_OCTETS, 8'h00, snmph_pkg::TAG_GET_REQ, 8'h00,
              snmph_pkg::TAG_INT, 8'h00, snmph_pkg::TAG_INT, 8'h00,
              snmph_pkg::TAG_INT, 8'h00, snmph_pkg::TAG_SEQ};
    send_message();
    msg_q = '{snmph_pkg::TAG_SEQ, 8'h81, 8'hFF, snmph_pkg::TAG_INT, 8'h01};
    send_message();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      target = summaries.sent_bytes + PHASE_BYTES;
      while (summaries.sent_bytes < target) begin
        if (ph == 0 && summaries.sent_bytes + PHASE_BYTES / 2 > target) begin
          hold_request = 1'b1;
        end
        build_message();
        send_message();
      end
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (summaries.pending() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (summaries.fail_count == 0 && summaries.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
